>>> hw/rtl/cbbr_pkg.sv
`default_nettype none

package cbbr_pkg;

    // Table sizes and field widths
    localparam int LEVEL_COUNT = 11;
    localparam int GRAY_COUNT  = LEVEL_COUNT + 1;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;

    localparam int COORD_W = 12;
    localparam int SIZE_W  = COORD_W + 1;
    localparam int STEP_W  = 17;
    localparam int THR_W   = 20;
    localparam int GRAY_W  = 8;
    localparam int IDX_W   = 4;
    localparam int REQ_W   = 2;

    localparam int THR_AW = $clog2(LEVEL_COUNT);
    localparam int LVL_W  = $clog2(GRAY_COUNT);
    localparam int BUF_AW = $clog2(MAX_WIDTH);

    // Radius arithmetic: Q0.16 coordinates, Q4.12 result
    localparam int PROD_W   = COORD_W + STEP_W;
    localparam int SQ_W     = 2 * PROD_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int SCALED_W = SUM_W + 3;
    localparam int V_SHIFT  = 20;
    localparam int V_W      = 16;

    // Stream and configuration port widths
    localparam int IN_DATA_W  = IDX_W + THR_W + GRAY_W;
    localparam int OUT_DATA_W = 2 * COORD_W + 2 * GRAY_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STEP_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_THR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GRAY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PIX  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP = 2'd3;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [SIZE_W-1:0] MIN_SIZE     = 13'd2;
    localparam logic [SIZE_W-1:0] MAX_W_SIZE   = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SIZE   = SIZE_W'(MAX_HEIGHT);
    localparam logic [STEP_W-1:0] X_STEP_RESET = 17'd103;
    localparam logic [STEP_W-1:0] Y_STEP_RESET = 17'd137;

    localparam logic [GRAY_W-1:0] GRAY_BLACK = 8'd0;
    localparam logic [GRAY_W-1:0] GRAY_WHITE = 8'd255;

    typedef enum logic [1:0] {
        KIND_THR,
        KIND_GRAY,
        KIND_PIX
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [IDX_W-1:0]    idx;
        logic [THR_W-1:0]    thr;
        logic [GRAY_W-1:0]   gray;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic                row_end;
        logic                frame_end;
    } t_cmd;

    typedef struct packed {
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
    } t_steps;

    typedef struct packed {
        t_cmd             cmd;
        logic [LVL_W-1:0] level;
    } t_lvl_item;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [GRAY_W-1:0]  band;
        logic               bvalid;
        logic [GRAY_W-1:0]  bgray;
        logic               frame_last;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/cbbr_front.sv
`default_nettype none

module cbbr_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [cbbr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  wire logic [cbbr_pkg::REQ_W-1:0]       i_s_tuser,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [cbbr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cbbr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_q_full,
    output logic                                  o_q_push,
    output cbbr_pkg::t_cmd                        o_q_data,
    output cbbr_pkg::t_steps                      o_steps
);
    import cbbr_pkg::*;

    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;
    logic [STEP_W-1:0]  r_x_step;
    logic [STEP_W-1:0]  r_y_step;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] n_row;
    logic [COORD_W-1:0] n_col;

    logic [IDX_W-1:0]  w_idx;
    logic [THR_W-1:0]  w_thr;
    logic [GRAY_W-1:0] w_gray;
    t_kind             w_kind;
    logic              w_keep;
    logic [SIZE_W-1:0] w_col_inc;
    logic [SIZE_W-1:0] w_row_inc;
    logic              w_row_end;
    logic              w_frame_end;
    logic              w_pix_push;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        if (v < MIN_SIZE) begin
            res = MIN_SIZE;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign w_idx  = i_s_tdata[IDX_W-1:0];
    assign w_thr  = i_s_tdata[IDX_W+THR_W-1:IDX_W];
    assign w_gray = i_s_tdata[IN_DATA_W-1:IDX_W+THR_W];

    // Sort requests; drop unknown types and out-of-range loads here
    always_comb begin
        w_keep = 1'b0;
        w_kind = KIND_PIX;
        unique case (i_s_tuser)
            REQ_THR: begin
                w_kind = KIND_THR;
                w_keep = (w_idx < IDX_W'(LEVEL_COUNT));
            end
            REQ_GRAY: begin
                w_kind = KIND_GRAY;
                w_keep = (w_idx <= IDX_W'(LEVEL_COUNT));
            end
            REQ_PIX: begin
                w_kind = KIND_PIX;
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign w_col_inc   = {1'b0, r_col} + SIZE_W'(1);
    assign w_row_inc   = {1'b0, r_row} + SIZE_W'(1);
    assign w_row_end   = (w_col_inc >= r_width);
    assign w_frame_end = w_row_end && (w_row_inc >= r_height);

    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && o_s_tready && w_keep;
    assign w_pix_push = o_q_push && (w_kind == KIND_PIX);

    always_comb begin
        o_q_data.kind      = w_kind;
        o_q_data.idx       = w_idx;
        o_q_data.thr       = w_thr;
        o_q_data.gray      = w_gray;
        o_q_data.row       = r_row;
        o_q_data.col       = r_col;
        o_q_data.row_end   = w_row_end;
        o_q_data.frame_end = w_frame_end;
    end

    assign o_steps.x_step = r_x_step;
    assign o_steps.y_step = r_y_step;

    // Advance raster position on each pixel request
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_pix_push) begin
            if (w_row_end) begin
                n_col = '0;
                n_row = w_frame_end ? '0 : w_row_inc[COORD_W-1:0];
            end else begin
                n_col = w_col_inc[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_x_step <= X_STEP_RESET;
            r_y_step <= Y_STEP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= clamp_size(i_cfg_data[SIZE_W-1:0], MAX_W_SIZE);
                CFG_HEIGHT: r_height <= clamp_size(i_cfg_data[SIZE_W-1:0], MAX_H_SIZE);
                CFG_X_STEP: r_x_step <= i_cfg_data[STEP_W-1:0];
                CFG_Y_STEP: r_y_step <= i_cfg_data[STEP_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cbbr_fifo.sv
`default_nettype none

module cbbr_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cbbr_pkg::t_cmd i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output cbbr_pkg::t_cmd      o_data,
    output logic                o_empty
);
    import cbbr_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/cbbr_band.sv
`default_nettype none

module cbbr_band (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire cbbr_pkg::t_cmd   i_cmd,
    input  wire cbbr_pkg::t_steps i_steps,
    output logic                  o_valid,
    output cbbr_pkg::t_lvl_item   o_item
);
    import cbbr_pkg::*;

    // Stage valids
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic r_v5;

    t_cmd r_c1;
    t_cmd r_c2;
    t_cmd r_c3;
    t_cmd r_c4;
    t_cmd r_c5;

    logic [PROD_W-1:0]  r_x;
    logic [PROD_W-1:0]  r_y;
    logic [SQ_W-1:0]    r_xx;
    logic [SQ_W-1:0]    r_yy;
    logic [SUM_W-1:0]   r_sum;
    logic [V_W-1:0]     r_v;
    logic [LVL_W-1:0]   r_level;
    logic [THR_W-1:0]   r_thr [LEVEL_COUNT];

    logic [SCALED_W-1:0] w_scaled;
    logic                w_sat;
    logic [THR_W-1:0]    w_v_ext;
    logic [LVL_W-1:0]    w_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // 7*s as 8*s - s, then to Q4.12 with saturation
    assign w_scaled = (SCALED_W'(r_sum) << 3) - SCALED_W'(r_sum);
    assign w_sat    = |w_scaled[SCALED_W-1:V_SHIFT+V_W];
    assign w_v_ext  = {{(THR_W-V_W){1'b0}}, r_v};

    // First level whose threshold is not below v
    always_comb begin
        w_level = LVL_W'(LEVEL_COUNT);
        for (int k = LEVEL_COUNT - 1; k >= 0; k--) begin
            if ($signed(w_v_ext) <= $signed(r_thr[k])) begin
                w_level = LVL_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= i_cmd;
            r_x  <= PROD_W'(i_cmd.col) * PROD_W'(i_steps.x_step);
            r_y  <= PROD_W'(i_cmd.row) * PROD_W'(i_steps.y_step);

            r_c2 <= r_c1;
            r_xx <= SQ_W'(r_x) * SQ_W'(r_x);
            r_yy <= SQ_W'(r_y) * SQ_W'(r_y);

            r_c3  <= r_c2;
            r_sum <= SUM_W'(r_xx) + SUM_W'(r_yy);

            r_c4 <= r_c3;
            r_v  <= w_sat ? '1 : w_scaled[V_SHIFT+V_W-1:V_SHIFT];

            r_c5    <= r_c4;
            r_level <= w_level;
        end
    end

    // Threshold loads land in request order with the pixels around them
    always_ff @(posedge i_clk) begin
        if (i_en && r_v4 && (r_c4.kind == KIND_THR)) begin
            r_thr[r_c4.idx[THR_AW-1:0]] <= r_c4.thr;
        end
    end

    assign o_valid      = r_v5;
    assign o_item.cmd   = r_c5;
    assign o_item.level = r_level;

endmodule

`default_nettype wire

>>> hw/rtl/cbbr_edge.sv
`default_nettype none

module cbbr_edge (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire cbbr_pkg::t_lvl_item i_item,
    input  wire logic                i_m_ready,
    output logic                     o_en,
    output logic                     o_m_valid,
    output cbbr_pkg::t_result        o_result
);
    import cbbr_pkg::*;

    logic [GRAY_W-1:0]  r_grays [GRAY_COUNT];
    logic [GRAY_W-1:0]  r_row_buf [MAX_WIDTH];

    logic               r_a_valid;
    logic [GRAY_W-1:0]  r_a_g;
    logic [COORD_W-1:0] r_a_row;
    logic [COORD_W-1:0] r_a_col;
    logic               r_a_row_end;
    logic               r_a_frame_end;
    logic [GRAY_W-1:0]  r_up;
    logic [GRAY_W-1:0]  r_right;

    logic               r_out_valid;
    t_result            r_out;

    logic [GRAY_W-1:0]  w_g;
    logic               w_pix;
    logic [BUF_AW-1:0]  w_addr;
    logic [BUF_AW-1:0]  w_addr_right;
    t_result            w_res;

    // Whole back pipeline moves only when the output register has room
    assign o_en = !r_out_valid || i_m_ready;

    assign w_g          = r_grays[i_item.level];
    assign w_pix        = i_valid && (i_item.cmd.kind == KIND_PIX);
    assign w_addr       = i_item.cmd.col[BUF_AW-1:0];
    assign w_addr_right = w_addr + BUF_AW'(1);

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid && (i_item.cmd.kind == KIND_GRAY)) begin
            r_grays[i_item.cmd.idx[LVL_W-1:0]] <= i_item.cmd.gray;
        end
    end

    // Read the row above before this pixel overwrites its own column
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_up    <= r_row_buf[w_addr];
            r_right <= r_row_buf[w_addr_right];
            if (w_pix) begin
                r_row_buf[w_addr] <= w_g;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_a_g         <= w_g;
            r_a_row       <= i_item.cmd.row;
            r_a_col       <= i_item.cmd.col;
            r_a_row_end   <= i_item.cmd.row_end;
            r_a_frame_end <= i_item.cmd.frame_end;
        end
    end

    always_comb begin
        w_res.row        = r_a_row;
        w_res.col        = r_a_col;
        w_res.band       = r_a_g;
        w_res.bvalid     = (r_a_row != '0);
        w_res.frame_last = r_a_frame_end;
        if (!w_res.bvalid) begin
            w_res.bgray = GRAY_BLACK;
        end else if (r_a_row_end) begin
            w_res.bgray = GRAY_WHITE;
        end else if ((r_a_g != r_up) || (r_up != r_right)) begin
            w_res.bgray = GRAY_BLACK;
        end else begin
            w_res.bgray = GRAY_WHITE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_a_valid   <= w_pix;
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_out <= w_res;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_result  = r_out;

`ifndef SYNTH
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |=> $stable(r_a_valid) && r_out_valid)
        else $error("pixel stage moved during output stall");

    a_bgray_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.bgray == GRAY_BLACK || r_out.bgray == GRAY_WHITE))
        else $error("boundary gray neither black nor white");

    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bvalid |-> r_out.row != '0)
        else $error("boundary given on first row");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/contour_band_and_boundary_raster_top.sv
`default_nettype none

// Channel   Dir  Handshake              Payload
// s         in   i_s_tvalid/o_s_tready  tdata: entry_index, threshold_value, gray_value
//                                       tuser: req_type
// m         out  o_m_tvalid/i_m_tready  tdata: pixel_row, pixel_col, band_gray,
//                                       boundary_gray; tuser: boundary_valid;
//                                       tlast: frame_last
// cfg       in   i_cfg_wr_en            i_cfg_index, i_cfg_data
//
// One request per clock while the queue has room; a pixel result goes through
// the queue, the five-stage radius/level pipeline, the row-buffer stage and the
// output register. Loads use one pipeline slot and give no result.
// A stall on the m side freezes the back pipeline; the 4-entry queue keeps
// taking requests until it fills. Reset is synchronous: it clears the raster
// position and queue and restores the size and step registers. Level tables and
// the row buffer hold no value until written.

module contour_band_and_boundary_raster_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // entry_index, threshold_value, gray_value
    input  wire logic [cbbr_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // req_type
    input  wire logic [cbbr_pkg::REQ_W-1:0]        i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // pixel_row, pixel_col, band_gray, boundary_gray
    output logic [cbbr_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    // boundary_valid
    output logic                                   o_m_tuser,
    output logic                                   o_m_tlast,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [cbbr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cbbr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cbbr_pkg::*;

    logic      w_q_push;
    logic      w_q_full;
    logic      w_q_empty;
    logic      w_pop;
    logic      w_en;
    t_cmd      w_q_in;
    t_cmd      w_q_out;
    t_steps    w_steps;
    logic      w_band_valid;
    t_lvl_item w_band_item;
    t_result   w_result;

    cbbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_in),
        .o_steps     (w_steps)
    );

    cbbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    assign w_pop = w_en && !w_q_empty;

    cbbr_band u_band (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!w_q_empty),
        .i_cmd   (w_q_out),
        .i_steps (w_steps),
        .o_valid (w_band_valid),
        .o_item  (w_band_item)
    );

    cbbr_edge u_edge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_band_valid),
        .i_item    (w_band_item),
        .i_m_ready (i_m_tready),
        .o_en      (w_en),
        .o_m_valid (o_m_tvalid),
        .o_result  (w_result)
    );

    assign o_m_tdata = {w_result.bgray, w_result.band, w_result.col, w_result.row};
    assign o_m_tuser = w_result.bvalid;
    assign o_m_tlast = w_result.frame_last;

endmodule

`default_nettype wire
